// ===== design/ash_pkg.sv =====
// Shared types, constants and byte functions of the ASH frame encoder.
package ash_pkg;

   localparam int MaxPayloadDef = 250;

   localparam logic [7:0]  FlagByte = 8'h7E;
   localparam logic [7:0]  EscByte  = 8'h7D;
   localparam logic [7:0]  EscXor   = 8'h20;
   localparam logic [15:0] CrcInit  = 16'hFFFF;
   localparam logic [15:0] CrcPoly  = 16'h1021;

   // segment mask: one bit per part of the output run, lowest bit goes first
   localparam int SegCount = 6;
   localparam logic [SegCount-1:0] SegOpen  = 6'b000001;
   localparam logic [SegCount-1:0] SegCtrl  = 6'b000010;
   localparam logic [SegCount-1:0] SegData  = 6'b000100;
   localparam logic [SegCount-1:0] SegCrcHi = 6'b001000;
   localparam logic [SegCount-1:0] SegCrcLo = 6'b010000;
   localparam logic [SegCount-1:0] SegClose = 6'b100000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] control_byte;
      logic       first;
      logic       last;
      logic       has_data;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_run;
      logic       frame_done;
      logic       truncated;
   } rsp_payload_type;

   // one item's worth of output, ready for serialization
   typedef struct packed {
      logic [SegCount-1:0] seg_mask;
      logic [7:0]          ctrl;
      logic [7:0]          data;
      logic [15:0]         crc;
      logic                trunc;
   } run_rec_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic needs_escape(input logic [7:0] b);
      return b inside {8'h7E, 8'h7D, 8'h11, 8'h13, 8'h18};
   endfunction

endpackage

// ===== design/ash_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface ash_req_if;
   logic                     valid;
   logic                     ready;
   ash_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ash_rsp_if;
   logic                     valid;
   logic                     ready;
   ash_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/ash_emitter.sv =====
// Output serializer: walks one item's segments and sends a byte per beat, stuffing as needed.
module ash_emitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  ash_pkg::run_rec_type load_rec,
   output logic                 load_ready,
   ash_rsp_if.source            rsp_chan
);
   import ash_pkg::*;

   logic [SegCount-1:0] mask_ff, mask_in;
   logic                esc_ff, esc_in;
   run_rec_type         rec_ff, rec_in;

   logic [SegCount-1:0] seg_oh;
   logic [SegCount-1:0] mask_rest;
   logic [7:0]          seg_byte;
   logic                is_flag;
   logic                need_esc;
   logic                seg_done;
   logic                fire;

   assign seg_oh    = mask_ff & (~mask_ff + 1'b1);
   assign mask_rest = mask_ff & ~seg_oh;

   always_comb begin
      case (seg_oh)
         SegCtrl:  seg_byte = rec_ff.ctrl;
         SegData:  seg_byte = rec_ff.data;
         SegCrcHi: seg_byte = rec_ff.crc[15:8];
         SegCrcLo: seg_byte = rec_ff.crc[7:0];
         default:  seg_byte = FlagByte;
      endcase
   end

   // flags go out raw; everything else may need an escape prefix
   assign is_flag  = (seg_oh == SegOpen) || (seg_oh == SegClose);
   assign need_esc = !is_flag && needs_escape(seg_byte);
   assign seg_done = !(need_esc && !esc_ff);

   assign rsp_chan.valid = |mask_ff;
   assign rsp_chan.payload.out_byte   = (need_esc && !esc_ff) ? EscByte :
                                        (esc_ff ? (seg_byte ^ EscXor) : seg_byte);
   assign rsp_chan.payload.end_of_run = seg_done && (mask_rest == '0);
   assign rsp_chan.payload.frame_done = (seg_oh == SegClose);
   assign rsp_chan.payload.truncated  = (seg_oh == SegClose) && rec_ff.trunc;

   assign fire       = rsp_chan.valid && rsp_chan.ready;
   assign load_ready = !rsp_chan.valid || (fire && rsp_chan.payload.end_of_run);

   always_comb begin
      mask_in = mask_ff;
      esc_in  = esc_ff;
      rec_in  = rec_ff;
      if (fire) begin
         if (seg_done) begin
            mask_in = mask_rest;
            esc_in  = 1'b0;
         end else begin
            esc_in = 1'b1;
         end
      end
      if (load_valid && load_ready) begin
         mask_in = load_rec.seg_mask;
         esc_in  = 1'b0;
         rec_in  = load_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         esc_ff  <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         esc_ff  <= esc_in;
      end
      rec_ff <= rec_in;
   end

endmodule

// ===== design/ash_frame_encoder.sv =====
// Path: a req beat goes into the input register, where it waits while the serializer is busy, then into the serializer.
// Output: one line byte per cycle while rsp is ready; an item causes 1 to 10 bytes
//   (a payload byte 1, or 2 when escaped), sent by the serializer.
// An item that causes no bytes is taken on the req side and loads nothing into the serializer.
// Reset: synchronous, clears the CRC to 0xFFFF, count and overflow to zero,
//   and empties both the input register and the serializer.
module ash_frame_encoder #(
   parameter int MaxPayload = ash_pkg::MaxPayloadDef
) (
   input  logic      clock,
   input  logic      reset,
   ash_req_if.sink   req_chan,
   ash_rsp_if.source rsp_chan
);
   import ash_pkg::*;

   localparam int CntW = $clog2(MaxPayload + 1);

   logic [15:0]     crc_ff, crc_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            ovf_ff, ovf_in;
   logic            a_valid_ff, a_valid_in;
   run_rec_type     a_rec_ff, a_rec_in;

   req_payload_type rq;
   logic            req_fire;
   logic            load_ready;
   logic [15:0]     crc0, crc1, crc2;
   logic [CntW-1:0] cnt0, cnt2;
   logic            ovf0, ovf2;
   logic            take;

   assign rq       = req_chan.payload;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !a_valid_ff || load_ready;

   always_comb begin
      crc0 = rq.first ? CrcInit : crc_ff;
      cnt0 = rq.first ? '0 : cnt_ff;
      ovf0 = rq.first ? 1'b0 : ovf_ff;
      crc1 = rq.first ? crc_update(CrcInit, rq.control_byte) : crc0;
      take = rq.has_data && (cnt0 < CntW'(MaxPayload));
      crc2 = take ? crc_update(crc1, rq.data_byte) : crc1;
      cnt2 = cnt0 + CntW'(take);
      ovf2 = ovf0 | (rq.has_data & ~take);

      a_rec_in.seg_mask = (rq.first ? (SegOpen | SegCtrl) : '0)
                        | (take ? SegData : '0)
                        | (rq.last ? (SegCrcHi | SegCrcLo | SegClose) : '0);
      a_rec_in.ctrl  = rq.control_byte;
      a_rec_in.data  = rq.data_byte;
      a_rec_in.crc   = crc2;
      a_rec_in.trunc = ovf2;

      crc_in = crc_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (req_fire) begin
         if (rq.last) begin
            crc_in = CrcInit;
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            crc_in = crc2;
            cnt_in = cnt2;
            ovf_in = ovf2;
         end
      end

      if (req_fire) begin
         a_valid_in = |a_rec_in.seg_mask;
      end else if (load_ready) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= CrcInit;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         crc_ff     <= crc_in;
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
         a_valid_ff <= a_valid_in;
      end
      if (req_fire) begin
         a_rec_ff <= a_rec_in;
      end
   end

   ash_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load_valid (a_valid_ff),
      .load_rec   (a_rec_ff),
      .load_ready (load_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== design/ash_chk.sv =====
// Port-level checks on the encoder's response stream, bound to the top level.
module ash_chk (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input ash_pkg::rsp_payload_type rsp_payload
);
   import ash_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_done |-> rsp_payload.end_of_run)
      else $error("closing flag is not the end of the run");

   a_done_is_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_done |-> rsp_payload.out_byte == FlagByte)
      else $error("frame_done on a byte other than the flag");

   a_trunc_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.truncated |-> rsp_payload.frame_done)
      else $error("truncated away from the closing flag");

   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_byte == EscByte |-> !rsp_payload.end_of_run)
      else $error("escape prefix ends a run");

endmodule

bind ash_frame_encoder ash_chk u_ash_chk (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_payload (rsp_chan.payload)
);
